// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL; every check is clocked on i_clk and
// held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ibws_pkg.sv =====
`default_nettype none
package ibws_pkg;

    localparam int VW = 64;
    localparam int PW = 128;
    localparam int IW = 35;
    localparam int WW = 42;
    localparam int CW = 41;
    localparam int QW = 48;
    localparam int DIV_STEPS = 168;

    typedef logic signed [VW-1:0] t_val;
    typedef logic signed [PW-1:0] t_wide;

    localparam t_val ONE_Q40   = 64'sd1099511627776;
    localparam t_val HALF_Q40  = 64'sd549755813888;
    localparam t_val GUESS_LIM = 64'sd17592186044416;
    localparam t_val LON_HI    = 64'sd9059696640;
    localparam t_val LON_TURN  = 64'sd6039797760;
    localparam logic [QW-1:0] CORR_LIM = 48'd70368744177664;

    localparam logic [7:0]    MAX_ITER_RST = 8'd100;
    localparam logic [CW-1:0] THRESH_RST   = 41'd110;

    localparam logic CFG_MAX_ITER = 1'b0;
    localparam logic CFG_THRESH   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOP,
        S_MUL,
        S_DETCHK,
        S_DINIT,
        S_DRUN,
        S_CHECK,
        S_FAIL,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        MOP_YCI, MOP_XCI, MOP_YAI, MOP_YBJ, MOP_YCIJ, MOP_XAI, MOP_XBJ, MOP_XCIJ,
        MOP_YCJ, MOP_XCJ, MOP_D1, MOP_D2, MOP_NI1, MOP_NI2, MOP_NJ1, MOP_NJ2,
        MOP_W0, MOP_W1, MOP_W2, MOP_W3
    } t_mop;

    function automatic t_val wrap_lon(input t_val d);
        t_val r;
        if (d > LON_HI) begin
            r = d - LON_TURN;
        end else if (d < -LON_HI) begin
            r = d + LON_TURN;
        end else begin
            r = d;
        end
        return r;
    endfunction

    function automatic t_val clamp_guess(input t_val v);
        t_val r;
        if (v > GUESS_LIM) begin
            r = GUESS_LIM;
        end else if (v < -GUESS_LIM) begin
            r = -GUESS_LIM;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [WW-1:0] sat_weight(input t_val v);
        t_val hi;
        logic [WW-1:0] r;
        hi = (t_val'(1) <<< (WW - 1)) - t_val'(1);
        if (v > hi) begin
            r = hi[WW-1:0];
        end else if (v < -hi - t_val'(1)) begin
            r = {1'b1, {(WW-1){1'b0}}};
        end else begin
            r = v[WW-1:0];
        end
        return r;
    endfunction

    function automatic logic [VW-1:0] mag(input t_val v);
        return v[VW-1] ? logic'(1'b0) - v : v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/inverse_bilinear_weight_solver_top.sv =====
`default_nettype none
// Inverse bilinear weight solver.
// Input channel: present the four corners and the target point (Q24 degrees)
// and raise start; the word is taken at a clock edge with start high and busy
// low. busy stays high until the result has been delivered.
// Output channel: o_done pulses for exactly one cycle with the four Q40
// weights and o_converged on the result ports. The receiver cannot stall:
// it must take the word in that cycle; the ports hold their value afterward.
// Each Newton iteration runs 16 products on one shared multiplier (four
// 32x32 partial products plus a write-back each) and two corrections on one
// shared restoring divider (each stops early when the quotient saturates).
// The strobe follows four weight products on convergence, or comes without
// them when the iteration limit runs out; items are processed one at a time.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0: iteration limit, 1: convergence threshold); write only while idle.
// Reset (synchronous, active low) restores limit 100 and threshold 110 and
// returns the sequencer to idle; no clearing pass is needed.
module inverse_bilinear_weight_solver_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire signed [ibws_pkg::IW-1:0]    i_corner0_lat,
    input  wire signed [ibws_pkg::IW-1:0]    i_corner1_lat,
    input  wire signed [ibws_pkg::IW-1:0]    i_corner2_lat,
    input  wire signed [ibws_pkg::IW-1:0]    i_corner3_lat,
    input  wire signed [ibws_pkg::IW-1:0]    i_corner0_lon,
    input  wire signed [ibws_pkg::IW-1:0]    i_corner1_lon,
    input  wire signed [ibws_pkg::IW-1:0]    i_corner2_lon,
    input  wire signed [ibws_pkg::IW-1:0]    i_corner3_lon,
    input  wire signed [ibws_pkg::IW-1:0]    i_target_lat,
    input  wire signed [ibws_pkg::IW-1:0]    i_target_lon,
    input  wire                              i_cfg_we,
    input  wire                              i_cfg_idx,
    input  wire        [ibws_pkg::CW-1:0]    i_cfg_data,
    output logic                             o_done,
    output logic signed [ibws_pkg::WW-1:0]   o_weight0,
    output logic signed [ibws_pkg::WW-1:0]   o_weight1,
    output logic signed [ibws_pkg::WW-1:0]   o_weight2,
    output logic signed [ibws_pkg::WW-1:0]   o_weight3,
    output logic                             o_converged
);
    import ibws_pkg::*;

    t_state r_state, n_state;

    // configuration
    logic [7:0]    r_max_iter;
    logic [CW-1:0] r_thresh;

    // cell geometry, fixed for the whole item
    t_val r_ya, r_yb, r_yc, r_xa, r_xb, r_xc, r_xt, r_ty;
    // Newton state
    t_val r_gi, r_gj, r_ci, r_cj;
    t_val r_yci, r_xci, r_ry, r_rx, r_j11, r_j12, r_j21, r_j22;
    t_wide r_det, r_numi, r_numj;
    logic [7:0] r_iter;

    // shared multiplier
    t_mop          r_op;
    logic [2:0]    r_mstep;
    logic [PW-1:0] r_acc;
    t_val          m_a, m_b;
    logic [VW-1:0] m_ua, m_ub;
    logic          m_neg;
    logic [31:0]   m_ah, m_bh;
    logic [63:0]   m_pp;
    logic [1:0]    m_hsum;
    logic [PW-1:0] m_shift;
    t_wide         m_prod;
    t_val          m_res40;
    logic          m_wb, m_last;

    // shared divider
    logic          r_dsel, r_dneg;
    logic [PW-1:0] r_nsh, r_rem, r_dd;
    logic [QW-1:0] r_q;
    logic [7:0]    r_dcnt;
    logic [PW:0]   d_trial, d_diff;
    logic          d_ge;
    logic [QW-1:0] d_qn, d_qfin;
    logic          d_satn, d_end;
    t_val          d_res;
    t_wide         d_num;

    logic          conv;
    logic          accept;

    assign accept = start && !busy;

    function automatic logic [PW-1:0] mag128(input t_wide v);
        return v[PW-1] ? logic'(1'b0) - v : v;
    endfunction

    // operand selection for the shared multiplier
    always_comb begin
        unique case (r_op)
            MOP_YCI:  begin m_a = r_yc;  m_b = r_gi;  end
            MOP_XCI:  begin m_a = r_xc;  m_b = r_gi;  end
            MOP_YAI:  begin m_a = r_ya;  m_b = r_gi;  end
            MOP_YBJ:  begin m_a = r_yb;  m_b = r_gj;  end
            MOP_YCIJ: begin m_a = r_yci; m_b = r_gj;  end
            MOP_XAI:  begin m_a = r_xa;  m_b = r_gi;  end
            MOP_XBJ:  begin m_a = r_xb;  m_b = r_gj;  end
            MOP_XCIJ: begin m_a = r_xci; m_b = r_gj;  end
            MOP_YCJ:  begin m_a = r_yc;  m_b = r_gj;  end
            MOP_XCJ:  begin m_a = r_xc;  m_b = r_gj;  end
            MOP_D1:   begin m_a = r_j11; m_b = r_j22; end
            MOP_D2:   begin m_a = r_j12; m_b = r_j21; end
            MOP_NI1:  begin m_a = r_ry;  m_b = r_j22; end
            MOP_NI2:  begin m_a = r_j12; m_b = r_rx;  end
            MOP_NJ1:  begin m_a = r_j11; m_b = r_rx;  end
            MOP_NJ2:  begin m_a = r_ry;  m_b = r_j21; end
            MOP_W0:   begin m_a = ONE_Q40 - r_gi; m_b = ONE_Q40 - r_gj; end
            MOP_W1:   begin m_a = r_gi;           m_b = ONE_Q40 - r_gj; end
            MOP_W2:   begin m_a = r_gi;           m_b = r_gj;           end
            MOP_W3:   begin m_a = ONE_Q40 - r_gi; m_b = r_gj;           end
            default:  begin m_a = '0;    m_b = '0;    end
        endcase
    end

    // one 32x32 partial product a cycle, sign applied at write-back
    always_comb begin
        m_ua    = mag(m_a);
        m_ub    = mag(m_b);
        m_neg   = m_a[VW-1] ^ m_b[VW-1];
        m_ah    = r_mstep[0] ? m_ua[63:32] : m_ua[31:0];
        m_bh    = r_mstep[1] ? m_ub[63:32] : m_ub[31:0];
        m_pp    = m_ah * m_bh;
        m_hsum  = {1'b0, r_mstep[0]} + {1'b0, r_mstep[1]};
        m_shift = {64'd0, m_pp} << {m_hsum, 5'd0};
        m_prod  = m_neg ? t_wide'(-r_acc) : t_wide'(r_acc);
        m_res40 = m_prod[103:40];
        m_wb    = (r_state == S_MUL) && (r_mstep == 3'd4);
        m_last  = (r_op == MOP_NJ2) || (r_op == MOP_W3);
    end

    // one restoring step of the divider
    always_comb begin
        d_trial = {r_rem, r_nsh[PW-1]};
        d_diff  = d_trial - {1'b0, r_dd};
        d_ge    = d_trial >= {1'b0, r_dd};
        d_qn    = {r_q[QW-2:0], d_ge};
        d_satn  = d_qn > CORR_LIM;
        d_end   = (r_dcnt == 8'(DIV_STEPS - 1)) || d_satn;
        d_qfin  = d_satn ? CORR_LIM : d_qn;
        d_res   = r_dneg ? -t_val'(d_qfin) : t_val'(d_qfin);
        d_num   = r_dsel ? r_numj : r_numi;
        conv    = (mag(r_ci) < {{(VW-CW){1'b0}}, r_thresh})
                  && (mag(r_cj) < {{(VW-CW){1'b0}}, r_thresh});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        busy    = (r_state != S_IDLE);
        o_done  = (r_state == S_DONE);
        unique case (r_state)
            S_IDLE:   if (start) n_state = S_LOOP;
            S_LOOP:   n_state = (r_iter == r_max_iter) ? S_FAIL : S_MUL;
            S_MUL: begin
                if (m_wb && m_last) begin
                    n_state = (r_op == MOP_W3) ? S_DONE : S_DETCHK;
                end
            end
            S_DETCHK: n_state = (r_det == '0) ? S_FAIL : S_DINIT;
            S_DINIT:  n_state = S_DRUN;
            S_DRUN:   if (d_end) n_state = r_dsel ? S_CHECK : S_DINIT;
            S_CHECK:  n_state = conv ? S_MUL : S_LOOP;
            S_FAIL:   n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RST;
            r_thresh   <= THRESH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[7:0];
                CFG_THRESH:   r_thresh   <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= MOP_YCI;
            r_mstep <= '0;
            r_iter  <= '0;
            r_dsel  <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            if (accept) begin
                r_iter <= '0;
            end
            if (r_state == S_LOOP) begin
                r_op    <= MOP_YCI;
                r_mstep <= '0;
                r_dsel  <= 1'b0;
            end
            if (r_state == S_MUL) begin
                if (m_wb) begin
                    r_mstep <= '0;
                    if (!m_last) r_op <= t_mop'(r_op + 5'd1);
                end else begin
                    r_mstep <= r_mstep + 3'd1;
                end
            end
            if (r_state == S_DINIT) begin
                r_dcnt <= '0;
            end
            if (r_state == S_DRUN) begin
                r_dcnt <= r_dcnt + 8'd1;
                if (d_end) r_dsel <= 1'b1;
            end
            if (r_state == S_CHECK) begin
                if (conv) begin
                    r_op    <= MOP_W0;
                    r_mstep <= '0;
                end else begin
                    r_iter <= r_iter + 8'd1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            // capture geometry; longitude steps are wrapped by a full turn
            r_ya <= t_val'(i_corner1_lat) - t_val'(i_corner0_lat);
            r_yb <= t_val'(i_corner3_lat) - t_val'(i_corner0_lat);
            r_yc <= t_val'(i_corner2_lat) - t_val'(i_corner1_lat)
                    - (t_val'(i_corner3_lat) - t_val'(i_corner0_lat));
            r_xa <= wrap_lon(t_val'(i_corner1_lon) - t_val'(i_corner0_lon));
            r_xb <= wrap_lon(t_val'(i_corner3_lon) - t_val'(i_corner0_lon));
            r_xc <= wrap_lon(t_val'(i_corner2_lon) - t_val'(i_corner1_lon))
                    - wrap_lon(t_val'(i_corner3_lon) - t_val'(i_corner0_lon));
            r_xt <= wrap_lon(t_val'(i_target_lon) - t_val'(i_corner0_lon));
            r_ty <= t_val'(i_target_lat) - t_val'(i_corner0_lat);
            r_gi <= HALF_Q40;
            r_gj <= HALF_Q40;
        end

        if ((r_state == S_MUL) && !m_wb) begin
            r_acc <= ((r_mstep == 3'd0) ? '0 : r_acc) + m_shift;
        end

        if (m_wb) begin
            case (r_op)
                MOP_YCI:  begin r_yci <= m_res40; r_j12 <= r_yb + m_res40; end
                MOP_XCI:  begin r_xci <= m_res40; r_j22 <= r_xb + m_res40; end
                MOP_YAI:  r_ry <= r_ty - m_res40;
                MOP_YBJ:  r_ry <= r_ry - m_res40;
                MOP_YCIJ: r_ry <= r_ry - m_res40;
                MOP_XAI:  r_rx <= r_xt - m_res40;
                MOP_XBJ:  r_rx <= r_rx - m_res40;
                MOP_XCIJ: r_rx <= r_rx - m_res40;
                MOP_YCJ:  r_j11 <= r_ya + m_res40;
                MOP_XCJ:  r_j21 <= r_xa + m_res40;
                MOP_D1:   r_det <= m_prod;
                MOP_D2:   r_det <= r_det - m_prod;
                MOP_NI1:  r_numi <= m_prod;
                MOP_NI2:  r_numi <= r_numi - m_prod;
                MOP_NJ1:  r_numj <= m_prod;
                MOP_NJ2:  r_numj <= r_numj - m_prod;
                MOP_W0:   o_weight0 <= sat_weight(m_res40);
                MOP_W1:   o_weight1 <= sat_weight(m_res40);
                MOP_W2:   o_weight2 <= sat_weight(m_res40);
                MOP_W3:   o_weight3 <= sat_weight(m_res40);
                default:  ;
            endcase
        end

        if (r_state == S_DINIT) begin
            // load magnitudes; the 40 trailing zero bits shift in on their own
            r_nsh  <= mag128(d_num);
            r_dd   <= mag128(r_det);
            r_dneg <= d_num[PW-1] ^ r_det[PW-1];
            r_rem  <= '0;
            r_q    <= '0;
        end

        if (r_state == S_DRUN) begin
            r_nsh  <= r_nsh << 1;
            r_rem  <= d_ge ? d_diff[PW-1:0] : d_trial[PW-1:0];
            r_q    <= d_qfin;
            if (d_end) begin
                if (r_dsel) r_cj <= d_res;
                else        r_ci <= d_res;
            end
        end

        if ((r_state == S_CHECK) && !conv) begin
            r_gi <= clamp_guess(r_gi + r_ci);
            r_gj <= clamp_guess(r_gj + r_cj);
        end
        if (r_state == S_CHECK) begin
            o_converged <= conv;
        end

        if (r_state == S_FAIL) begin
            o_weight0   <= '0;
            o_weight1   <= '0;
            o_weight2   <= '0;
            o_weight3   <= '0;
            o_converged <= 1'b0;
        end
    end

    `include "assert_macros.svh"

    `ASSERT_NEXT(a_done_pulse, o_done, !o_done, "result strobe longer than one cycle")
    `ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not raise busy")
    `ASSERT_IMPL(a_fail_zero, o_done && !o_converged,
        (o_weight0 == '0) && (o_weight1 == '0) && (o_weight2 == '0) && (o_weight3 == '0),
        "failed solve with nonzero weights")
    `ASSERT_ALWAYS(a_guess_lim, (r_state == S_IDLE) || ((r_gi <= GUESS_LIM)
        && (r_gi >= -GUESS_LIM) && (r_gj <= GUESS_LIM) && (r_gj >= -GUESS_LIM)),
        "guess outside clamp range")
    `ASSERT_IMPL(a_div_nonzero, r_state == S_DRUN, r_dd != '0, "divide by zero determinant")

endmodule
`default_nettype wire
